// ===== hw/rtl/heartbeat_master_election_core_defines.svh =====
// assertion macros for the election core checker
`ifndef HEARTBEAT_MASTER_ELECTION_CORE_DEFINES_SVH
`define HEARTBEAT_MASTER_ELECTION_CORE_DEFINES_SVH

// checked at every edge outside reset
`define HME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define HME_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/hme_pkg.sv =====
`timescale 1ns / 1ps
package hme_pkg;

  localparam int unsigned TypeW    = 2;
  localparam int unsigned IdW      = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned DelayW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned OutDataW = 16;

  localparam logic [TypeW-1:0] REQ_TICK      = 2'd0;
  localparam logic [TypeW-1:0] REQ_HEARTBEAT = 2'd1;
  localparam logic [TypeW-1:0] REQ_CANDIDATE = 2'd2;
  localparam logic [TypeW-1:0] REQ_OTHER     = 2'd3;

  localparam logic KIND_HEARTBEAT = 1'b0;
  localparam logic KIND_CANDIDATE = 1'b1;

  localparam logic [IdW-1:0] NO_CANDIDATE = 8'hFF;

  localparam logic [CfgIdxW-1:0] CFG_OWN_ID           = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEARTBEAT_PERIOD = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEARCH_WINDOW    = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_MASTER_TIMEOUT   = 8'd3;

  localparam logic [IdW-1:0]    RST_OWN_ID           = 8'd0;
  localparam logic [DelayW-1:0] RST_HEARTBEAT_PERIOD = 16'd1000;
  localparam logic [DelayW-1:0] RST_SEARCH_WINDOW    = 16'd1000;
  localparam logic [DelayW-1:0] RST_MASTER_TIMEOUT   = 16'd3000;

  typedef struct packed {
    logic [IdW-1:0]    own_id;
    logic [DelayW-1:0] heartbeat_period;
    logic [DelayW-1:0] search_window;
    logic [DelayW-1:0] master_timeout;
  } cfg_t;

  typedef struct packed {
    logic           send_valid;
    logic           send_kind;
    logic [IdW-1:0] send_id;
    logic           master_now;
    logic           role_changed;
    logic           search_active;
  } result_t;

endpackage

// ===== hw/rtl/hme_cfg_regs.sv =====
`timescale 1ns / 1ps
module hme_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [hme_pkg::CfgIdxW-1:0] wr_index_i,
  input  logic [hme_pkg::DelayW-1:0]  wr_data_i,
  output hme_pkg::cfg_t               cfg_o
);

  hme_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (wr_index_i)
        hme_pkg::CFG_OWN_ID:           cfg_d.own_id = wr_data_i[hme_pkg::IdW-1:0];
        hme_pkg::CFG_HEARTBEAT_PERIOD: cfg_d.heartbeat_period = wr_data_i;
        hme_pkg::CFG_SEARCH_WINDOW:    cfg_d.search_window = wr_data_i;
        hme_pkg::CFG_MASTER_TIMEOUT:   cfg_d.master_timeout = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_id           <= hme_pkg::RST_OWN_ID;
      cfg_q.heartbeat_period <= hme_pkg::RST_HEARTBEAT_PERIOD;
      cfg_q.search_window    <= hme_pkg::RST_SEARCH_WINDOW;
      cfg_q.master_timeout   <= hme_pkg::RST_MASTER_TIMEOUT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/hme_update.sv =====
`timescale 1ns / 1ps
module hme_update #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [hme_pkg::TypeW-1:0] req_type_i,
  input  logic [hme_pkg::IdW-1:0]   sender_id_i,
  input  hme_pkg::cfg_t             cfg_i,
  output hme_pkg::result_t          res_o
);

  localparam int unsigned CntW = $clog2(NODE_COUNT + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(NODE_COUNT);

  logic [hme_pkg::TimeW-1:0] time_q, time_d;
  logic [hme_pkg::TimeW-1:0] heard_q, heard_d;
  logic [hme_pkg::TimeW-1:0] sent_q, sent_d;
  logic [hme_pkg::TimeW-1:0] start_q, start_d;
  logic                      master_q, master_d;
  logic                      search_q, search_d;
  logic [hme_pkg::IdW-1:0]   lowest_q, lowest_d;
  logic [CntW-1:0]           cnt_q, cnt_d;

  logic [hme_pkg::TimeW-1:0] time_inc;
  logic                      hb_due, window_over, timed_out;
  logic                      send, kind;

  assign time_inc    = time_q + 32'd1;
  assign hb_due      = (time_inc - sent_q) > {16'd0, cfg_i.heartbeat_period};
  assign window_over = (time_inc - start_q) > {16'd0, cfg_i.search_window};
  assign timed_out   = (time_inc - heard_q) > {16'd0, cfg_i.master_timeout};

  always_comb begin
    time_d   = time_q;
    heard_d  = heard_q;
    sent_d   = sent_q;
    start_d  = start_q;
    master_d = master_q;
    search_d = search_q;
    lowest_d = lowest_q;
    cnt_d    = cnt_q;
    send     = 1'b0;
    kind     = hme_pkg::KIND_HEARTBEAT;
    case (req_type_i)
      hme_pkg::REQ_TICK: begin
        time_d = time_inc;
        if (master_q) begin
          if (hb_due) begin
            sent_d = time_inc;
            send   = 1'b1;
            kind   = hme_pkg::KIND_HEARTBEAT;
          end
        end else if (search_q) begin
          if (window_over) begin
            search_d = 1'b0;
            lowest_d = hme_pkg::NO_CANDIDATE;
            cnt_d    = '0;
            if (!(lowest_q < cfg_i.own_id)) master_d = 1'b1;
            else heard_d = time_inc;
          end
        end else if (timed_out) begin
          search_d = 1'b1;
          start_d  = time_inc;
          send     = 1'b1;
          kind     = hme_pkg::KIND_CANDIDATE;
        end
      end
      hme_pkg::REQ_HEARTBEAT: begin
        heard_d  = time_q;
        master_d = 1'b0;
        if (search_q) begin
          search_d = 1'b0;
          lowest_d = hme_pkg::NO_CANDIDATE;
          cnt_d    = '0;
        end
      end
      hme_pkg::REQ_CANDIDATE: begin
        if (!search_q) begin
          search_d = 1'b1;
          start_d  = time_q;
          send     = 1'b1;
          kind     = hme_pkg::KIND_CANDIDATE;
        end
        if (cnt_q < CntMax) begin
          if (sender_id_i < lowest_q) lowest_d = sender_id_i;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.send_valid    = send;
    res_o.send_kind     = send ? kind : 1'b0;
    res_o.send_id       = send ? cfg_i.own_id : '0;
    res_o.master_now    = master_d;
    res_o.role_changed  = master_d != master_q;
    res_o.search_active = search_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q   <= '0;
      heard_q  <= '0;
      sent_q   <= '0;
      start_q  <= '0;
      master_q <= 1'b0;
      search_q <= 1'b0;
      lowest_q <= hme_pkg::NO_CANDIDATE;
      cnt_q    <= '0;
    end else if (step_i) begin
      time_q   <= time_d;
      heard_q  <= heard_d;
      sent_q   <= sent_d;
      start_q  <= start_d;
      master_q <= master_d;
      search_q <= search_d;
      lowest_q <= lowest_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/heartbeat_master_election_core.sv =====
`timescale 1ns / 1ps
// pipeline: an input transfer is registered in the input register, its result in the result register
// throughput: one item per cycle while the output is not stalled; the state update sits
//   between the input register and the result register and its result is combinational
// reset: asynchronous, active low; clears the valid flags of both pipeline registers and
//   the election state, and loads the configuration registers with their defaults
module heartbeat_master_election_core #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hme_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hme_pkg::DelayW-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [hme_pkg::IdW-1:0]      s_axis_tdata_i,   // sender_id
  input  logic [hme_pkg::TypeW-1:0]    s_axis_tuser_i,   // req_type
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // send_valid, send_id[8:1], master_now, role_changed, search_active, zero pad
  output logic [hme_pkg::OutDataW-1:0] m_axis_tdata_o,
  output logic                         m_axis_tuser_o    // send_kind
);

  hme_pkg::cfg_t    cfg;
  hme_pkg::result_t res;
  hme_pkg::result_t out_q;

  logic                      in_valid_q, in_valid_d;
  logic [hme_pkg::TypeW-1:0] in_type_q;
  logic [hme_pkg::IdW-1:0]   in_id_q;
  logic                      out_valid_q, out_valid_d;
  logic                      advance, in_take;

  assign cfg_ready_o = 1'b1;

  hme_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign in_valid_d      = in_take || (in_valid_q && !advance);
  assign out_valid_d     = advance || (out_valid_q && !m_axis_tready_i);

  hme_update #(
    .NODE_COUNT (NODE_COUNT)
  ) u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .req_type_i  (in_type_q),
    .sender_id_i (in_id_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_type_q <= s_axis_tuser_i;
      in_id_q   <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.send_kind;
  assign m_axis_tdata_o  = {4'd0, out_q.search_active, out_q.role_changed,
                            out_q.master_now, out_q.send_id, out_q.send_valid};

endmodule

// ===== hw/rtl/hme_checker.sv =====
`timescale 1ns / 1ps
`include "heartbeat_master_election_core_defines.svh"
module hme_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         m_valid_i,
  input logic                         m_ready_i,
  input logic [hme_pkg::OutDataW-1:0] m_data_i,
  input logic                         m_user_i
);

  `HME_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !m_valid_i, "result during reset")
  `HME_ASSERT(a_result_held,
              m_valid_i && !m_ready_i |=> m_valid_i && $stable(m_data_i) && $stable(m_user_i),
              "stalled result changed")
  `HME_ASSERT(a_idle_send_zero,
              m_valid_i && !m_data_i[0] |-> m_data_i[8:1] == 8'd0 && m_user_i == hme_pkg::KIND_HEARTBEAT,
              "send fields set without send")
  `HME_ASSERT(a_heartbeat_master,
              m_valid_i && m_data_i[0] && m_user_i == hme_pkg::KIND_HEARTBEAT |-> m_data_i[9] && !m_data_i[10],
              "heartbeat from non-master")
  `HME_ASSERT(a_candidate_search,
              m_valid_i && m_data_i[0] && m_user_i == hme_pkg::KIND_CANDIDATE |-> m_data_i[11],
              "announcement without search")

endmodule

bind heartbeat_master_election_core hme_checker u_hme_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_valid_i (m_axis_tvalid_o),
  .m_ready_i (m_axis_tready_i),
  .m_data_i  (m_axis_tdata_o),
  .m_user_i  (m_axis_tuser_o)
);

// ===== bench/hme_election_checker.sv =====
`timescale 1ns / 1ps
module hme_election_checker #(
  parameter int unsigned NODE_COUNT = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [hme_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hme_pkg::DelayW-1:0]   cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic                         s_tready_i,
  input  logic [hme_pkg::IdW-1:0]      s_tdata_i,
  input  logic [hme_pkg::TypeW-1:0]    s_tuser_i,
  input  logic                         m_tvalid_i,
  input  logic                         m_tready_i,
  input  logic [hme_pkg::OutDataW-1:0] m_tdata_i,
  input  logic                         m_tuser_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  pending_o
);
  import hme_pkg::*;

  cfg_t             regs;
  logic [TimeW-1:0] now_ms;
  logic [TimeW-1:0] heard_ms;
  logic [TimeW-1:0] sent_ms;
  logic [TimeW-1:0] search_ms;
  logic             master_q;
  logic             searching_q;
  logic [IdW-1:0]   lowest_id;
  int unsigned      cand_count;
  result_t          outcome_q[$];
  int unsigned      fail_count = 0;

  assign fail_count_o = fail_count;

  function automatic void clear_search();
    searching_q = 1'b0;
    lowest_id   = NO_CANDIDATE;
    cand_count  = 0;
  endfunction

  function automatic result_t elect_step(logic [TypeW-1:0] req, logic [IdW-1:0] sender);
    result_t r;
    logic    was_master;
    logic    sending;
    logic    what;
    logic    promote;
    was_master = master_q;
    sending    = 1'b0;
    what       = KIND_HEARTBEAT;
    case (req)
      REQ_TICK: begin
        now_ms = now_ms + 1;
        if (master_q) begin
          if (now_ms - sent_ms > regs.heartbeat_period) begin
            sent_ms = now_ms;
            sending = 1'b1;
            what    = KIND_HEARTBEAT;
          end
        end else if (searching_q) begin
          if (now_ms - search_ms > regs.search_window) begin
            promote = !(lowest_id < regs.own_id);
            clear_search();
            if (promote) master_q = 1'b1;
            else heard_ms = now_ms;
          end
        end else if (now_ms - heard_ms > regs.master_timeout) begin
          searching_q = 1'b1;
          search_ms   = now_ms;
          sending     = 1'b1;
          what        = KIND_CANDIDATE;
        end
      end
      REQ_HEARTBEAT: begin
        heard_ms = now_ms;
        master_q = 1'b0;
        if (searching_q) clear_search();
      end
      REQ_CANDIDATE: begin
        if (!searching_q) begin
          searching_q = 1'b1;
          search_ms   = now_ms;
          sending     = 1'b1;
          what        = KIND_CANDIDATE;
        end
        if (cand_count < NODE_COUNT) begin
          if (sender < lowest_id) lowest_id = sender;
          cand_count++;
        end
      end
      default: begin
      end
    endcase
    r.send_valid    = sending;
    r.send_kind     = sending ? what : 1'b0;
    r.send_id       = sending ? regs.own_id : '0;
    r.master_now    = master_q;
    r.role_changed  = master_q != was_master;
    r.search_active = searching_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [IdW-1:0] want, logic [IdW-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      regs.own_id           = RST_OWN_ID;
      regs.heartbeat_period = RST_HEARTBEAT_PERIOD;
      regs.search_window    = RST_SEARCH_WINDOW;
      regs.master_timeout   = RST_MASTER_TIMEOUT;
      now_ms      = '0;
      heard_ms    = '0;
      sent_ms     = '0;
      search_ms   = '0;
      master_q    = 1'b0;
      clear_search();
      outcome_q.delete();
      pending_o   = 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (outcome_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected transfer: expected none, actual tdata %0h tuser %0h",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          want = outcome_q.pop_front();
          check_field("send_valid", want.send_valid, m_tdata_i[0]);
          check_field("send_kind", want.send_kind, m_tuser_i);
          check_field("send_id", want.send_id, m_tdata_i[8:1]);
          check_field("master_now", want.master_now, m_tdata_i[9]);
          check_field("role_changed", want.role_changed, m_tdata_i[10]);
          check_field("search_active", want.search_active, m_tdata_i[11]);
          check_field("pad", '0, m_tdata_i[15:12]);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN_ID:           regs.own_id           = cfg_data_i[IdW-1:0];
          CFG_HEARTBEAT_PERIOD: regs.heartbeat_period = cfg_data_i;
          CFG_SEARCH_WINDOW:    regs.search_window    = cfg_data_i;
          CFG_MASTER_TIMEOUT:   regs.master_timeout   = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (s_tvalid_i && s_tready_i) outcome_q.push_back(elect_step(s_tuser_i, s_tdata_i));
      pending_o = outcome_q.size();
    end
  end

endmodule

// ===== bench/tb_heartbeat_master_election_core.sv =====
`timescale 1ns / 1ps
module tb_heartbeat_master_election_core;
  import hme_pkg::*;

  localparam int unsigned NODE_COUNT      = 16;
  localparam int unsigned PHASES          = 9;
  localparam int unsigned ITEMS_PER_PHASE = 70;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [DelayW-1:0]   cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [IdW-1:0]      s_tdata   = '0;
  logic [TypeW-1:0]    s_tuser   = REQ_OTHER;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned items_sent   = 0;
  int unsigned reg_writes   = 0;
  int unsigned fail_count;
  int unsigned pending;

  always #2 clk = ~clk;

  heartbeat_master_election_core #(
    .NODE_COUNT(NODE_COUNT)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  hme_election_checker #(
    .NODE_COUNT(NODE_COUNT)
  ) u_election_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= rx_stall_pct);

  task automatic send_item(input logic [TypeW-1:0] req, input logic [IdW-1:0] sender);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= sender;
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    reg_writes++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // upper byte of the own id write is junk and must be dropped
  task automatic load_settings(input logic [IdW-1:0] own, input logic [DelayW-1:0] period,
                               input logic [DelayW-1:0] window,
                               input logic [DelayW-1:0] timeout);
    settle();
    write_reg(CFG_OWN_ID, {8'($urandom_range(255)), own});
    write_reg(CFG_HEARTBEAT_PERIOD, period);
    write_reg(CFG_SEARCH_WINDOW, window);
    write_reg(CFG_MASTER_TIMEOUT, timeout);
    write_reg(8'($urandom_range(4, 255)), 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DelayW-1:0] pick_delay();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 10));
    endcase
  endfunction

  task automatic run_traffic(input int unsigned count);
    int unsigned done;
    int unsigned shape;
    int unsigned len;
    done = 0;
    while (done < count) begin
      shape = $urandom_range(99);
      if (shape < 45) begin
        len = $urandom_range(1, 12);
        repeat (len) send_item(REQ_TICK, 8'($urandom));
        done += len;
      end else if (shape < 65) begin
        // bursts past the list size exercise the full candidate list
        len = $urandom_range(1, 20);
        repeat (len) send_item(REQ_CANDIDATE, 8'($urandom));
        done += len;
      end else if (shape < 75) begin
        send_item(REQ_HEARTBEAT, 8'($urandom));
        done++;
      end else if (shape < 85) begin
        send_item(REQ_OTHER, 8'($urandom));
        done++;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_item(2'($urandom), 8'($urandom));
        done += len;
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(REQ_OTHER, 8'hFF);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_HEARTBEAT, 8'hAA);
    load_settings(8'd5, 16'd2, 16'd3, 16'd2);
    // timeout, search with a higher candidate, promotion
    repeat (3) send_item(REQ_TICK, 8'h5A);
    send_item(REQ_CANDIDATE, 8'h09);
    send_item(REQ_CANDIDATE, 8'hFF);
    repeat (4) send_item(REQ_TICK, 8'hA5);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_OTHER, 8'h00);
    // candidate while master, then demotion
    send_item(REQ_CANDIDATE, 8'h00);
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_HEARTBEAT, 8'h55);
    // search lost to a lower id
    repeat (3) send_item(REQ_TICK, 8'h0F);
    send_item(REQ_CANDIDATE, 8'h03);
    repeat (4) send_item(REQ_TICK, 8'hF0);

    for (int unsigned p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        tx_idle_pct  = 26;
        rx_stall_pct = 48;
      end else if (p < 6) begin
        tx_idle_pct  = 48;
        rx_stall_pct = 26;
      end else begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      if (p == 0) load_settings(8'd254, '0, '0, '0);
      else if (p == 3) load_settings(8'd0, '1, '1, '1);
      else load_settings(8'($urandom_range(254)), pick_delay(), pick_delay(), pick_delay());
      run_traffic(ITEMS_PER_PHASE);
    end

    settle();
    repeat (10) @(negedge clk);
    $display("run covered %0d input transfers and %0d register writes over %0d settings",
             items_sent, reg_writes, PHASES + 1);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
